// ----- hw/rtl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers; empty when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_IMPLIES(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(name, clk, rst_n, ante, cons)
`define ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif

`endif

// ----- hw/rtl/rfc_pkg.sv -----
// ---------------------------------------------------------------------------
// rfc_pkg
// Types, codes and helpers shared by the rectangle fill command stream.
// ---------------------------------------------------------------------------
package rfc_pkg;

  localparam int PANEL_WIDTH_DEF  = 240;
  localparam int PANEL_HEIGHT_DEF = 240;

  localparam int COORD_W     = 10;
  localparam int SIZE_W      = 11;
  localparam int COLOR_W     = 16;
  localparam int EXT_W       = 12;
  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 16;
  localparam int OUT_TUSER_W = 3;

  localparam logic [7:0] OP_COLUMN_WINDOW = 8'h2A;
  localparam logic [7:0] OP_ROW_WINDOW    = 8'h2B;
  localparam logic [7:0] OP_MEMORY_WRITE  = 8'h2C;

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_PULL  = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_EMIT   = 2'd0,
    ST_ACCEPT = 2'd1,
    ST_REJECT = 2'd2,
    ST_IDLE   = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_COL_CMD  = 3'd1,
    PH_COL_DATA = 3'd2,
    PH_ROW_CMD  = 3'd3,
    PH_ROW_DATA = 3'd4,
    PH_MEM_CMD  = 3'd5,
    PH_PIXELS   = 3'd6
  } phase_t;

  typedef struct packed {
    cmd_t                 cmd;
    logic [COORD_W-1:0]   x_start;
    logic [COORD_W-1:0]   y_start;
    logic [SIZE_W-1:0]    rect_width;
    logic [SIZE_W-1:0]    rect_height;
    logic [COLOR_W-1:0]   color;
  } item_t;

  typedef struct packed {
    status_t     status;
    logic [7:0]  out_byte;
    logic        is_data;
    logic        frame_end;
    logic        last;
  } result_t;

  typedef struct packed {
    logic fire;
    logic busy;
  } eng_ctrl_t;

  function automatic logic [7:0] window_byte(logic [COORD_W-1:0] lo,
                                             logic [COORD_W-1:0] hi,
                                             logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = {6'd0, lo[9:8]};
      2'd1:    b = lo[7:0];
      2'd2:    b = {6'd0, hi[9:8]};
      default: b = hi[7:0];
    endcase
    return b;
  endfunction

endpackage

// ----- hw/rtl/rfc_in_stage.sv -----
// ---------------------------------------------------------------------------
// rfc_in_stage
// Input register: captures one transaction and unpacks its fields.
// ---------------------------------------------------------------------------
module rfc_in_stage (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [rfc_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic                            in_tuser,
  output logic                            item_valid,
  output rfc_pkg::item_t                  item,
  input  logic                            pop
);

  logic           valid_r;
  logic           valid_nxt;
  rfc_pkg::item_t item_r;
  rfc_pkg::item_t item_nxt;
  logic           take;

  assign in_tready = !valid_r || pop;
  assign take      = in_tvalid && in_tready;

  always_comb begin
    item_nxt.cmd         = rfc_pkg::cmd_t'(in_tuser);
    item_nxt.x_start     = in_tdata[9:0];
    item_nxt.y_start     = in_tdata[19:10];
    item_nxt.rect_width  = in_tdata[30:20];
    item_nxt.rect_height = in_tdata[41:31];
    item_nxt.color       = in_tdata[57:42];
    if (take) begin
      valid_nxt = 1'b1;
    end else if (pop) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r <= item_nxt;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

// ----- hw/rtl/rfc_engine.sv -----
// ---------------------------------------------------------------------------
// rfc_engine
// Phase machine, window registers and pixel counters; one result per item.
// ---------------------------------------------------------------------------
module rfc_engine #(
  parameter int PANEL_WIDTH  = rfc_pkg::PANEL_WIDTH_DEF,
  parameter int PANEL_HEIGHT = rfc_pkg::PANEL_HEIGHT_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  rfc_pkg::item_t      item,
  input  rfc_pkg::eng_ctrl_t  ctrl_in,
  output logic                busy,
  output rfc_pkg::result_t    res
);

  localparam logic [rfc_pkg::EXT_W-1:0] PW = rfc_pkg::EXT_W'(PANEL_WIDTH);
  localparam logic [rfc_pkg::EXT_W-1:0] PH = rfc_pkg::EXT_W'(PANEL_HEIGHT);

  rfc_pkg::phase_t                  phase_r, phase_nxt;
  logic [1:0]                       byte_index_r, byte_index_nxt;
  logic [rfc_pkg::COORD_W-1:0]      col_count_r, col_count_nxt;
  logic [rfc_pkg::COORD_W-1:0]      row_count_r, row_count_nxt;
  logic                             low_half_r, low_half_nxt;
  logic [rfc_pkg::COORD_W-1:0]      win_x0_r, win_x0_nxt;
  logic [rfc_pkg::COORD_W-1:0]      win_x1_r, win_x1_nxt;
  logic [rfc_pkg::COORD_W-1:0]      win_y0_r, win_y0_nxt;
  logic [rfc_pkg::COORD_W-1:0]      win_y1_r, win_y1_nxt;
  logic [rfc_pkg::COLOR_W-1:0]      fill_color_r, fill_color_nxt;

  logic [rfc_pkg::EXT_W-1:0]        x_ext, y_ext, sum_x, sum_y, end_x, end_y;
  logic [rfc_pkg::COORD_W-1:0]      cols, rows;
  logic                             reject;

  always_comb begin
    x_ext  = {2'd0, item.x_start};
    y_ext  = {2'd0, item.y_start};
    sum_x  = x_ext + {1'b0, item.rect_width};
    sum_y  = y_ext + {1'b0, item.rect_height};
    end_x  = sum_x - rfc_pkg::EXT_W'(1);
    end_y  = sum_y - rfc_pkg::EXT_W'(1);
    cols   = win_x1_r - win_x0_r;
    rows   = win_y1_r - win_y0_r;
    reject = (phase_r != rfc_pkg::PH_IDLE) || (item.rect_width == '0) ||
             (item.rect_height == '0) || (x_ext >= PW) || (y_ext >= PH) ||
             (sum_x > PW) || (sum_y > PH);

    phase_nxt      = phase_r;
    byte_index_nxt = byte_index_r;
    col_count_nxt  = col_count_r;
    row_count_nxt  = row_count_r;
    low_half_nxt   = low_half_r;
    win_x0_nxt     = win_x0_r;
    win_x1_nxt     = win_x1_r;
    win_y0_nxt     = win_y0_r;
    win_y1_nxt     = win_y1_r;
    fill_color_nxt = fill_color_r;
    res            = '0;
    res.status     = rfc_pkg::ST_EMIT;

    if (item.cmd == rfc_pkg::CMD_START) begin
      if (reject) begin
        res.status = rfc_pkg::ST_REJECT;
      end else begin
        res.status     = rfc_pkg::ST_ACCEPT;
        win_x0_nxt     = item.x_start;
        win_x1_nxt     = end_x[rfc_pkg::COORD_W-1:0];
        win_y0_nxt     = item.y_start;
        win_y1_nxt     = end_y[rfc_pkg::COORD_W-1:0];
        fill_color_nxt = item.color;
        byte_index_nxt = '0;
        col_count_nxt  = '0;
        row_count_nxt  = '0;
        low_half_nxt   = 1'b0;
        phase_nxt      = rfc_pkg::PH_COL_CMD;
      end
    end else begin
      case (phase_r)
        rfc_pkg::PH_COL_CMD: begin
          phase_nxt      = rfc_pkg::PH_COL_DATA;
          byte_index_nxt = '0;
          res.out_byte   = rfc_pkg::OP_COLUMN_WINDOW;
        end
        rfc_pkg::PH_COL_DATA: begin
          res.out_byte  = rfc_pkg::window_byte(win_x0_r, win_x1_r, byte_index_r);
          res.is_data   = 1'b1;
          res.frame_end = (byte_index_r == 2'd3);
          byte_index_nxt = byte_index_r + 2'd1;
          if (byte_index_r == 2'd3) begin
            phase_nxt = rfc_pkg::PH_ROW_CMD;
          end
        end
        rfc_pkg::PH_ROW_CMD: begin
          phase_nxt      = rfc_pkg::PH_ROW_DATA;
          byte_index_nxt = '0;
          res.out_byte   = rfc_pkg::OP_ROW_WINDOW;
        end
        rfc_pkg::PH_ROW_DATA: begin
          res.out_byte  = rfc_pkg::window_byte(win_y0_r, win_y1_r, byte_index_r);
          res.is_data   = 1'b1;
          res.frame_end = (byte_index_r == 2'd3);
          byte_index_nxt = byte_index_r + 2'd1;
          if (byte_index_r == 2'd3) begin
            phase_nxt = rfc_pkg::PH_MEM_CMD;
          end
        end
        rfc_pkg::PH_MEM_CMD: begin
          phase_nxt     = rfc_pkg::PH_PIXELS;
          col_count_nxt = '0;
          row_count_nxt = '0;
          low_half_nxt  = 1'b0;
          res.out_byte  = rfc_pkg::OP_MEMORY_WRITE;
          res.frame_end = 1'b1;
        end
        rfc_pkg::PH_PIXELS: begin
          res.is_data = 1'b1;
          if (low_half_r) begin
            res.out_byte = fill_color_r[7:0];
            low_half_nxt = 1'b0;
            if (col_count_r == cols) begin
              col_count_nxt = '0;
              if (row_count_r == rows) begin
                row_count_nxt = '0;
                phase_nxt     = rfc_pkg::PH_IDLE;
                res.frame_end = 1'b1;
                res.last      = 1'b1;
              end else begin
                row_count_nxt = row_count_r + 1'b1;
              end
            end else begin
              col_count_nxt = col_count_r + 1'b1;
            end
          end else begin
            res.out_byte = fill_color_r[15:8];
            low_half_nxt = 1'b1;
          end
        end
        default: begin
          phase_nxt  = rfc_pkg::PH_IDLE;
          res.status = rfc_pkg::ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= rfc_pkg::PH_IDLE;
      byte_index_r <= '0;
      col_count_r  <= '0;
      row_count_r  <= '0;
      low_half_r   <= 1'b0;
      win_x0_r     <= '0;
      win_x1_r     <= '0;
      win_y0_r     <= '0;
      win_y1_r     <= '0;
      fill_color_r <= '0;
    end else if (ctrl_in.fire) begin
      phase_r      <= phase_nxt;
      byte_index_r <= byte_index_nxt;
      col_count_r  <= col_count_nxt;
      row_count_r  <= row_count_nxt;
      low_half_r   <= low_half_nxt;
      win_x0_r     <= win_x0_nxt;
      win_x1_r     <= win_x1_nxt;
      win_y0_r     <= win_y0_nxt;
      win_y1_r     <= win_y1_nxt;
      fill_color_r <= fill_color_nxt;
    end
  end

  assign busy = (phase_r != rfc_pkg::PH_IDLE) && ctrl_in.busy;

endmodule

// ----- hw/rtl/rfc_out_stage.sv -----
// ---------------------------------------------------------------------------
// rfc_out_stage
// Result register: holds one transaction until the sink takes it.
// ---------------------------------------------------------------------------
module rfc_out_stage (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             load,
  input  rfc_pkg::result_t                 res,
  output logic                             slot_free,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [rfc_pkg::OUT_TDATA_W-1:0]  out_tdata,   // out_byte[7:0], frame_end[8]
  output logic [rfc_pkg::OUT_TUSER_W-1:0]  out_tuser,   // status[1:0], is_data[2]
  output logic                             out_tlast
);

  logic             valid_r;
  logic             valid_nxt;
  rfc_pkg::result_t res_r;

  assign slot_free = !valid_r || out_tready;

  always_comb begin
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {7'd0, res_r.frame_end, res_r.out_byte};
  assign out_tuser  = {res_r.is_data, res_r.status};
  assign out_tlast  = res_r.last;

endmodule

// ----- hw/rtl/rect_fill_command_stream_core.sv -----
// ---------------------------------------------------------------------------
// rect_fill_command_stream_core
// Turns rectangle fill requests into the display byte stream, one per pull.
// ---------------------------------------------------------------------------
//  channel  direction  payload
//  in_      sink       tuser cmd; tdata x/y start, width, height, colour
//  out_     source     tuser status, is_data; tdata byte, frame_end; tlast
//
//  One transaction per cycle while the result slot drains; the input and
//  result registers lie between input and result. The phase machine and
//  counters in rfc_engine decide each byte combinationally.
//  Synchronous active-low reset clears the phase, counters and valid flags.
//  A stalled output holds its result; the input register keeps taking
//  transactions as long as the result slot drains.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module rect_fill_command_stream_core #(
  parameter int PANEL_WIDTH  = rfc_pkg::PANEL_WIDTH_DEF,
  parameter int PANEL_HEIGHT = rfc_pkg::PANEL_HEIGHT_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // x_start[9:0], y_start[19:10], rect_width[30:20], rect_height[41:31],
  // color[57:42], zero [63:58]
  input  logic [rfc_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  logic                             in_tuser,    // cmd[0]
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [rfc_pkg::OUT_TDATA_W-1:0]  out_tdata,   // out_byte[7:0], frame_end[8]
  output logic [rfc_pkg::OUT_TUSER_W-1:0]  out_tuser,   // status[1:0], is_data[2]
  output logic                             out_tlast
);

  logic               item_valid;
  rfc_pkg::item_t     item;
  logic               slot_free;
  logic               fire;
  logic               eng_busy;
  rfc_pkg::result_t   eng_res;
  rfc_pkg::eng_ctrl_t eng_ctrl;

  assign fire          = item_valid && slot_free;
  assign eng_ctrl.fire = fire;
  assign eng_ctrl.busy = rst_n;

  rfc_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .item_valid (item_valid),
    .item       (item),
    .pop        (fire)
  );

  rfc_engine #(
    .PANEL_WIDTH  (PANEL_WIDTH),
    .PANEL_HEIGHT (PANEL_HEIGHT)
  ) u_engine (
    .clk     (clk),
    .rst_n   (rst_n),
    .item    (item),
    .ctrl_in (eng_ctrl),
    .busy    (eng_busy),
    .res     (eng_res)
  );

  rfc_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (fire),
    .res        (eng_res),
    .slot_free  (slot_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  `ASSERT_IMPLIES(a_last_ends_frame, clk, rst_n, out_tvalid && out_tlast, out_tdata[8] && out_tuser[2] && (out_tuser[1:0] == rfc_pkg::ST_EMIT))
  `ASSERT_IMPLIES(a_status_zero_payload, clk, rst_n, out_tvalid && (out_tuser[1:0] != rfc_pkg::ST_EMIT), (out_tdata == '0) && !out_tuser[2] && !out_tlast)
  `ASSERT_NEXT(a_accept_starts_fill, clk, rst_n, fire && (eng_res.status == rfc_pkg::ST_ACCEPT), eng_busy)
  `ASSERT_NEXT(a_final_byte_idles, clk, rst_n, fire && eng_res.last, !eng_busy)

endmodule
